// ----- sv/bpau_pkg.sv -----
// bus priority arbitration unit: shared types and constants
// no dependencies; every other file of the block uses this package

package bpau_pkg;

  // level masks: bits 0..3 are BR4..BR7, bit 4 is NPR
  localparam int LVL_W      = 5;
  localparam int BR_W       = 4;
  localparam int PRIO_W     = 3;
  localparam int FUNC_W     = 2;
  localparam int MODE_W     = 2;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // default width of the sack timer
  localparam int TIMER_BITS_DEF = 16;

  // lowest interrupt level, BR4 sits at bit 0
  localparam int BR_LEVEL_BASE = 4;

  typedef logic [LVL_W-1:0] lvl_mask_t;

  localparam lvl_mask_t NPR_MASK = 5'b10000;
  localparam lvl_mask_t BR_MASK  = 5'b01111;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_POLL    = 2'd0,
    FUNC_POST    = 2'd1,
    FUNC_INIT    = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_t;

  // arbitration modes, code 3 behaves as no arbitration
  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_DEVICE  = 2'd1,
    MODE_ARBITER = 2'd2
  } mode_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARB_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SACK_TIMEOUT = 1'b1;

  localparam logic [MODE_W-1:0]    MODE_RESET    = 2'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    func_t                  func;
    lvl_mask_t              request_mask;
    logic                   cpu_access;
    logic                   allow_intr_grant;
    lvl_mask_t              grant_in_mask;
    lvl_mask_t              forwarded_mask;
    lvl_mask_t              bus_requests_sensed;
    logic                   bbsy_line;
    logic                   sack_line;
    logic                   ssyn_line;
    logic [PRIO_W-1:0]      cpu_prio;
    logic                   cpu_level_valid;
  } req_t;

  typedef struct packed {
    lvl_mask_t granted_mask;
    lvl_mask_t request_lines;
    lvl_mask_t grant_out_mask;
    logic      sack_drive;
  } rsp_t;

  typedef struct packed {
    logic [MODE_W-1:0]    arbitration_mode;
    logic [TIMEOUT_W-1:0] sack_timeout_ticks;
  } cfg_t;

endpackage

// ----- sv/bpau_if.sv -----
// valid/ready channel interfaces for the request and result beats
// depends on bpau_pkg

interface bpau_req_if;
  logic                             valid;
  logic                             ready;
  logic [bpau_pkg::FUNC_W-1:0]      func;
  logic [bpau_pkg::LVL_W-1:0]       request_mask;
  logic                             cpu_access;
  logic                             allow_intr_grant;
  logic [bpau_pkg::LVL_W-1:0]       grant_in_mask;
  logic [bpau_pkg::LVL_W-1:0]       forwarded_mask;
  logic [bpau_pkg::LVL_W-1:0]       bus_requests_sensed;
  logic                             bbsy_line;
  logic                             sack_line;
  logic                             ssyn_line;
  logic [bpau_pkg::PRIO_W-1:0]      cpu_prio;
  logic                             cpu_level_valid;

  modport source (
    output valid, func, request_mask, cpu_access, allow_intr_grant, grant_in_mask,
           forwarded_mask, bus_requests_sensed, bbsy_line, sack_line, ssyn_line,
           cpu_prio, cpu_level_valid,
    input  ready
  );

  modport sink (
    input  valid, func, request_mask, cpu_access, allow_intr_grant, grant_in_mask,
           forwarded_mask, bus_requests_sensed, bbsy_line, sack_line, ssyn_line,
           cpu_prio, cpu_level_valid,
    output ready
  );
endinterface

interface bpau_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bpau_pkg::LVL_W-1:0]  granted_mask;
  logic [bpau_pkg::LVL_W-1:0]  request_lines;
  logic [bpau_pkg::LVL_W-1:0]  grant_out_mask;
  logic                        sack_drive;

  modport source (
    output valid, granted_mask, request_lines, grant_out_mask, sack_drive,
    input  ready
  );

  modport sink (
    input  valid, granted_mask, request_lines, grant_out_mask, sack_drive,
    output ready
  );
endinterface

// ----- sv/bus_priority_arbitration_unit.sv -----
// top level of the bus priority arbitration unit
// depends on bpau_pkg, bpau_if, bpau_in_stage, bpau_engine, bpau_out_stage
//
// usage:
//   req is the item channel (valid/ready); each beat is a poll tick, a
//   request post, an init abort or a sack release, with the sensed lines.
//   rsp returns exactly one result beat per request beat, in order.
//   wr_en/wr_index/wr_data write arbitration_mode (index 0) and
//   sack_timeout_ticks (index 1); write only while no beat is in flight.
// order: an accepted beat waits in the input register, is processed as it
//   moves into the result register, and its result is offered from there.
// throughput: one beat per cycle while rsp is taken; the state update of
//   a beat is a single pass of masks and a four-way priority encode between
//   the input register and the result register.
// reset: all arbitration state clears, mode returns to device client,
//   timeout to 1000 ticks; both channels come up empty.
// stall: while rsp is held, one result waits in the result register and
//   one more beat waits in the input register, then req.ready drops.

module bus_priority_arbitration_unit #(
  parameter int TIMER_BITS = bpau_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  bpau_req_if.sink                            req,
  bpau_rsp_if.source                          rsp,
  input  logic                                wr_en,
  input  logic [bpau_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [bpau_pkg::CFG_DATA_W-1:0]     wr_data
);

  logic             item_valid;
  logic             room;
  logic             advance;
  bpau_pkg::req_t   item;
  bpau_pkg::rsp_t   result;
  bpau_pkg::cfg_t   cfg;

  assign advance = item_valid && room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arbitration_mode   <= bpau_pkg::MODE_RESET;
      cfg.sack_timeout_ticks <= bpau_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        bpau_pkg::REG_ARB_MODE: begin
          cfg.arbitration_mode <= wr_data[bpau_pkg::MODE_W-1:0];
        end
        bpau_pkg::REG_SACK_TIMEOUT: begin
          cfg.sack_timeout_ticks <= wr_data[bpau_pkg::TIMEOUT_W-1:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  bpau_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bpau_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  bpau_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .result (result),
    .room   (room),
    .rsp    (rsp)
  );

endmodule

// ----- sv/bpau_in_stage.sv -----
// input register: captures one request beat and holds it until processed
// depends on bpau_pkg and bpau_req_if

module bpau_in_stage (
  input  logic             clk,
  input  logic             rst,
  bpau_req_if.sink         req,
  input  logic             advance,
  output logic             item_valid,
  output bpau_pkg::req_t   item
);

  logic accept;

  // free when empty or when the held item moves on this cycle
  assign req.ready = !item_valid || advance;
  assign accept    = req.valid && req.ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item.func                <= bpau_pkg::func_t'(req.func);
      item.request_mask        <= req.request_mask;
      item.cpu_access          <= req.cpu_access;
      item.allow_intr_grant    <= req.allow_intr_grant;
      item.grant_in_mask       <= req.grant_in_mask;
      item.forwarded_mask      <= req.forwarded_mask;
      item.bus_requests_sensed <= req.bus_requests_sensed;
      item.bbsy_line           <= req.bbsy_line;
      item.sack_line           <= req.sack_line;
      item.ssyn_line           <= req.ssyn_line;
      item.cpu_prio            <= req.cpu_prio;
      item.cpu_level_valid     <= req.cpu_level_valid;
    end
  end

endmodule

// ----- sv/bpau_engine.sv -----
// arbitration state and the per-beat update for all three modes
// depends on bpau_pkg

module bpau_engine #(
  parameter int TIMER_BITS = bpau_pkg::TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  bpau_pkg::req_t   item,
  input  bpau_pkg::cfg_t   cfg,
  output bpau_pkg::rsp_t   result
);

  localparam int LOAD_W = (TIMER_BITS > bpau_pkg::TIMEOUT_W) ? TIMER_BITS
                                                              : bpau_pkg::TIMEOUT_W;

  bpau_pkg::lvl_mask_t    pending_requests, pending_requests_next;
  bpau_pkg::lvl_mask_t    wait_clear_grant, wait_clear_grant_next;
  logic                   cpu_access_pending, cpu_access_pending_next;
  logic                   intr_arb_pending, intr_arb_pending_next;
  bpau_pkg::lvl_mask_t    arbiter_grant, arbiter_grant_next;
  logic [TIMER_BITS-1:0]  sack_timer, sack_timer_next;
  logic                   sack_asserted, sack_asserted_next;
  bpau_pkg::lvl_mask_t    grant_out_latch, grant_out_latch_next;

  bpau_pkg::lvl_mask_t    granted;
  bpau_pkg::lvl_mask_t    mine;
  logic [bpau_pkg::BR_W-1:0] br;
  logic [1:0]             br_idx;
  logic [bpau_pkg::PRIO_W-1:0] br_level;
  logic [TIMER_BITS-1:0]  timer_dec;
  logic [TIMER_BITS-1:0]  timer_load;
  logic [LOAD_W-1:0]      timeout_ext;
  logic [LOAD_W-1:0]      timer_max_ext;

  // timeout saturated to the timer width
  assign timeout_ext   = LOAD_W'(cfg.sack_timeout_ticks);
  assign timer_max_ext = LOAD_W'({TIMER_BITS{1'b1}});
  assign timer_load    = (timeout_ext > timer_max_ext) ? timer_max_ext[TIMER_BITS-1:0]
                                                       : timeout_ext[TIMER_BITS-1:0];

  // timer counts down toward zero on each arbitrator poll
  assign timer_dec = (sack_timer != '0)
                   ? sack_timer - {{(TIMER_BITS-1){1'b0}}, 1'b1}
                   : sack_timer;

  // highest sensed interrupt request
  assign br = item.bus_requests_sensed[bpau_pkg::BR_W-1:0];
  always_comb begin
    br_idx = 2'd0;
    for (int i = 0; i < bpau_pkg::BR_W; i++) begin
      if (br[i]) begin
        br_idx = 2'(i);
      end
    end
  end
  assign br_level = {1'b0, br_idx} + bpau_pkg::PRIO_W'(bpau_pkg::BR_LEVEL_BASE);

  assign mine = item.grant_in_mask & pending_requests & ~item.forwarded_mask;

  // next state and granted level
  always_comb begin
    pending_requests_next   = pending_requests;
    wait_clear_grant_next   = wait_clear_grant;
    cpu_access_pending_next = cpu_access_pending;
    intr_arb_pending_next   = intr_arb_pending;
    arbiter_grant_next      = arbiter_grant;
    sack_timer_next         = sack_timer;
    sack_asserted_next      = sack_asserted;
    grant_out_latch_next    = grant_out_latch;
    granted                 = '0;

    unique case (item.func)
      bpau_pkg::FUNC_POLL: begin
        unique case (cfg.arbitration_mode)
          bpau_pkg::MODE_DEVICE: begin
            // device client; grant-out latch holds
            if (cpu_access_pending && !item.bus_requests_sensed[4] &&
                !item.sack_line && !item.bbsy_line &&
                !((|br) && intr_arb_pending)) begin
              cpu_access_pending_next = 1'b0;
              granted                 = bpau_pkg::NPR_MASK;
            end else if (wait_clear_grant == '0) begin
              if (mine != '0) begin
                sack_asserted_next    = 1'b1;
                pending_requests_next = pending_requests & ~mine;
                wait_clear_grant_next = mine;
              end
            end else if ((item.grant_in_mask & wait_clear_grant) == '0 &&
                         !item.bbsy_line && !item.ssyn_line) begin
              granted               = wait_clear_grant;
              wait_clear_grant_next = '0;
            end
          end
          bpau_pkg::MODE_ARBITER: begin
            // acting arbitrator: NPR first, then highest BR above cpu level
            sack_timer_next = timer_dec;
            if (item.sack_line) begin
              arbiter_grant_next = '0;
              sack_timer_next    = '0;
            end else if (item.bus_requests_sensed[4]) begin
              if (arbiter_grant == '0) begin
                arbiter_grant_next = bpau_pkg::NPR_MASK;
                sack_timer_next    = timer_load;
              end
            end else if (intr_arb_pending && (|br)) begin
              if (arbiter_grant == '0 && br_level > item.cpu_prio &&
                  item.cpu_level_valid) begin
                arbiter_grant_next = bpau_pkg::lvl_mask_t'(1) << br_idx;
                sack_timer_next    = timer_load;
              end
            end else if (arbiter_grant != '0 && timer_dec == '0) begin
              arbiter_grant_next = '0;
            end
            grant_out_latch_next  = arbiter_grant_next;
            intr_arb_pending_next = 1'b0;
            granted               = arbiter_grant_next;
          end
          default: begin
            // no arbitration: pass grant-in, acknowledge NPR only
            grant_out_latch_next = item.grant_in_mask;
            if (pending_requests[4]) begin
              pending_requests_next = pending_requests & ~bpau_pkg::NPR_MASK;
              granted               = bpau_pkg::NPR_MASK;
            end
          end
        endcase
      end
      bpau_pkg::FUNC_POST: begin
        pending_requests_next   = pending_requests | item.request_mask;
        cpu_access_pending_next = cpu_access_pending | item.cpu_access;
        if (item.allow_intr_grant) begin
          intr_arb_pending_next = 1'b1;
        end
      end
      bpau_pkg::FUNC_INIT: begin
        pending_requests_next   = '0;
        sack_asserted_next      = 1'b0;
        wait_clear_grant_next   = '0;
        cpu_access_pending_next = 1'b0;
        arbiter_grant_next      = '0;
        sack_timer_next         = '0;
      end
      bpau_pkg::FUNC_RELEASE: begin
        sack_asserted_next = 1'b0;
      end
      default: begin
        sack_asserted_next = sack_asserted;
      end
    endcase
  end

  // result of this beat, taken from the updated state
  assign result.granted_mask   = granted;
  assign result.request_lines  = (cfg.arbitration_mode == bpau_pkg::MODE_DEVICE)
                               ? pending_requests_next : '0;
  assign result.grant_out_mask = grant_out_latch_next;
  assign result.sack_drive     = sack_asserted_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_requests   <= '0;
      wait_clear_grant   <= '0;
      cpu_access_pending <= 1'b0;
      intr_arb_pending   <= 1'b0;
      arbiter_grant      <= '0;
      sack_timer         <= '0;
      sack_asserted      <= 1'b0;
      grant_out_latch    <= '0;
    end else if (fire) begin
      pending_requests   <= pending_requests_next;
      wait_clear_grant   <= wait_clear_grant_next;
      cpu_access_pending <= cpu_access_pending_next;
      intr_arb_pending   <= intr_arb_pending_next;
      arbiter_grant      <= arbiter_grant_next;
      sack_timer         <= sack_timer_next;
      sack_asserted      <= sack_asserted_next;
      grant_out_latch    <= grant_out_latch_next;
    end
  end

`ifndef SYNTHESIS
  // arbitrator never issues more than one level
  a_grant_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(arbiter_grant))
    else $error("arbiter grant has more than one level");

  // timer only runs while a grant stands
  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    (arbiter_grant == '0) |-> (sack_timer == '0))
    else $error("sack timer running without a grant");

  // init abort drops sack and the grant
  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && item.func == bpau_pkg::FUNC_INIT) |=>
      (!sack_asserted && arbiter_grant == '0 && wait_clear_grant == '0))
    else $error("init abort left sack or grant state");
`endif

endmodule

// ----- sv/bpau_out_stage.sv -----
// result register: holds one result beat until the receiver takes it
// depends on bpau_pkg and bpau_rsp_if

module bpau_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bpau_pkg::rsp_t   result,
  output logic             room,
  bpau_rsp_if.source       rsp
);

  logic rsp_valid;

  assign room      = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.granted_mask   <= result.granted_mask;
      rsp.request_lines  <= result.request_lines;
      rsp.grant_out_mask <= result.grant_out_mask;
      rsp.sack_drive     <= result.sack_drive;
    end
  end

endmodule
